>>> sv/cma_pkg.sv
// Shared constants and controller/datapath command and status types
// for the centered moving average filter. No dependencies.
package cma_pkg;

	localparam int MAX_WINDOW_DEF   = 32;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int WIN_FIELD_W      = 6;

	localparam logic [WIN_FIELD_W-1:0] WIN_RESET = 6'd3;

	typedef struct packed {
		logic ld_in;
		logic upd;
		logic mul;
		logic emit_main;
		logic tail_rd;
		logic emit_tail;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic main_due;
		logic last;
		logic tail_none;
		logic tail_one;
		logic out_free;
	} sts_t;

endpackage

>>> sv/cma_in_if.sv
// Sample stream channel: valid/ready handshake with sample and end mark.
// Depends on cma_pkg for the default sample width.
interface cma_in_if #(
	parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           final_sample;

	modport source (output valid, sample, final_sample, input ready);
	modport sink   (input valid, sample, final_sample, output ready);
endinterface

>>> sv/cma_out_if.sv
// Result stream channel: valid/ready handshake with value and flags.
// Depends on cma_pkg for the default sample width.
interface cma_out_if #(
	parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] value;
	logic                           averaged;
	logic                           end_of_run;

	modport source (output valid, value, averaged, end_of_run, input ready);
	modport sink   (input valid, value, averaged, end_of_run, output ready);
endinterface

>>> sv/cma_ctrl.sv
// Sequencing state machine of the centered moving average filter.
// Depends on cma_pkg for the command and status types.
module cma_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cma_pkg::sts_t sts,
	output cma_pkg::cmd_t cmd
);
	import cma_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_TRD   = 3'd4;
	localparam logic [2:0] ST_TEMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.ld_in = 1'b1;
					state_nxt = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd   = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				if (sts.main_due) begin
					state_nxt = ST_EMIT;
				end else if (sts.last) begin
					state_nxt = ST_TRD;
				end else begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_main = 1'b1;
					if (sts.last && !sts.tail_none) begin
						state_nxt = ST_TRD;
					end else begin
						cmd.finish = 1'b1;
						state_nxt  = ST_IDLE;
					end
				end
			end
			ST_TRD: begin
				cmd.tail_rd = 1'b1;
				state_nxt   = ST_TEMIT;
			end
			ST_TEMIT: begin
				cmd.tail_rd = 1'b1;
				if (sts.out_free) begin
					cmd.emit_tail = 1'b1;
					if (sts.tail_one) begin
						cmd.finish = 1'b1;
						state_nxt  = ST_IDLE;
					end else begin
						state_nxt = ST_TRD;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> sv/cma_datapath.sv
// Delay line, running sum, reciprocal divide and output register of the
// centered moving average filter. Depends on cma_pkg; driven by cma_ctrl.
module cma_datapath #(
	parameter int MAX_WINDOW   = cma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cma_pkg::cmd_t                       cmd,
	output cma_pkg::sts_t                       sts,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	input  logic                                final_sample,
	input  logic                                cfg_we,
	input  logic [cma_pkg::WIN_FIELD_W-1:0]     cfg_wdata,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      value,
	output logic                                averaged,
	output logic                                end_of_run
);
	import cma_pkg::*;

	localparam int PTR_W  = $clog2(MAX_WINDOW);
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
	localparam int SHIFT  = SUM_W + WIN_W;
	localparam int RCP_W  = SHIFT + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam int SB_W   = PTR_W + 2;
	localparam int EXT_W  = (WIN_FIELD_W > WIN_W) ? WIN_FIELD_W : WIN_W;

	function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_FIELD_W-1:0] raw);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(raw);
		if (ext == '0) begin
			return WIN_W'(1);
		end else if (ext > EXT_W'(MAX_WINDOW)) begin
			return WIN_W'(MAX_WINDOW);
		end else begin
			return ext[WIN_W-1:0];
		end
	endfunction

	function automatic logic [PTR_W-1:0] slot_back(input logic [PTR_W-1:0] cur,
			input logic [WIN_W-1:0] back);
		logic [SB_W-1:0] t;
		t = SB_W'(cur) + SB_W'(MAX_WINDOW) - SB_W'(back);
		if (t >= SB_W'(MAX_WINDOW)) begin
			t = t - SB_W'(MAX_WINDOW);
		end
		return t[PTR_W-1:0];
	endfunction

	localparam logic [WIN_W-1:0] W_RST = eff_window(WIN_RESET);
	localparam logic [RCP_W:0] RCP_NUM_RST = {2'b01, {SHIFT{1'b0}}} + (RCP_W+1)'(W_RST - 1);
	localparam logic [RCP_W:0] RCP_RST = RCP_NUM_RST / (RCP_W+1)'(W_RST);

	logic [RCP_W-1:0] rcp_tab [0:MAX_WINDOW];

	for (genvar g = 0; g <= MAX_WINDOW; g++) begin : g_rcp
		if (g == 0) begin : g_zero
			assign rcp_tab[g] = '0;
		end else begin : g_val
			localparam logic [RCP_W:0] NUM = {2'b01, {SHIFT{1'b0}}} + (RCP_W+1)'(g - 1);
			localparam logic [RCP_W:0] QUO = NUM / (RCP_W+1)'(g);
			assign rcp_tab[g] = QUO[RCP_W-1:0];
		end
	end

	logic signed [SAMPLE_WIDTH-1:0] mem [0:MAX_WINDOW-1];

	logic [WIN_W-1:0]               w_q;
	logic [RCP_W-1:0]               rcp_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic [PTR_W-1:0]               wp_q;
	logic [WIN_W-1:0]               seen_q;
	logic [WIN_W-1:0]               back_q;
	logic signed [SAMPLE_WIDTH-1:0] s_q;
	logic                           last_q;
	logic signed [SAMPLE_WIDTH-1:0] rd_q;
	logic signed [SAMPLE_WIDTH-1:0] raw_q;
	logic [PROD_W-1:0]              prod_s1;
	logic                           neg_s1;
	logic                           ovalid_q;
	logic signed [SAMPLE_WIDTH-1:0] oval_q;
	logic                           oavg_q;
	logic                           oend_q;

	logic [WIN_W-1:0]        w_cfg;
	logic [WIN_W-1:0]        half;
	logic [WIN_W-1:0]        dly;
	logic                    main_due;
	logic                    avg_en;
	logic [PTR_W-1:0]        rd_addr;
	logic [SUM_W-1:0]        mag;
	logic [SAMPLE_WIDTH:0]   quo;
	logic [SAMPLE_WIDTH:0]   avg_v;
	logic                    emit;

	assign w_cfg    = eff_window(cfg_wdata);
	assign half     = w_q >> 1;
	assign dly      = w_q - WIN_W'(1) - half;
	assign main_due = (seen_q >= dly);
	assign avg_en   = (seen_q >= w_q - WIN_W'(1)) && (!last_q || w_q[0]);
	assign mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign quo      = prod_s1[SHIFT +: SAMPLE_WIDTH+1];
	assign avg_v    = neg_s1 ? (SAMPLE_WIDTH+1)'(-quo) : quo;
	assign emit     = cmd.emit_main || cmd.emit_tail;

	always_comb begin
		rd_addr = slot_back(wp_q, w_q);
		if (cmd.upd) begin
			rd_addr = slot_back(wp_q, dly);
		end else if (cmd.tail_rd) begin
			rd_addr = slot_back(wp_q, back_q - WIN_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			mem[wp_q] <= s_q;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			s_q <= sample;
		end
		if (cmd.mul) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(rcp_q);
			neg_s1  <= sum_q[SUM_W-1];
			raw_q   <= (dly == '0) ? s_q : rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= W_RST;
			rcp_q  <= RCP_RST[RCP_W-1:0];
			sum_q  <= '0;
			wp_q   <= '0;
			seen_q <= '0;
			back_q <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.ld_in) begin
				last_q <= final_sample;
			end
			if (cmd.mul) begin
				back_q <= main_due ? dly : seen_q + WIN_W'(1);
			end else if (cmd.emit_tail) begin
				back_q <= back_q - WIN_W'(1);
			end
			if (cfg_we) begin
				w_q    <= w_cfg;
				rcp_q  <= rcp_tab[w_cfg];
				sum_q  <= '0;
				wp_q   <= '0;
				seen_q <= '0;
			end else if (cmd.upd) begin
				sum_q <= sum_q - ((seen_q >= w_q) ? SUM_W'(rd_q) : SUM_W'(0)) + SUM_W'(s_q);
			end else if (cmd.finish) begin
				if (last_q) begin
					sum_q  <= '0;
					wp_q   <= '0;
					seen_q <= '0;
				end else begin
					wp_q   <= (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + PTR_W'(1);
					seen_q <= (seen_q == WIN_W'(MAX_WINDOW)) ? seen_q : seen_q + WIN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_main) begin
			oval_q <= avg_en ? avg_v[SAMPLE_WIDTH-1:0] : raw_q;
			oavg_q <= avg_en;
			oend_q <= last_q && (dly == '0);
		end else if (cmd.emit_tail) begin
			oval_q <= rd_q;
			oavg_q <= 1'b0;
			oend_q <= (back_q == WIN_W'(1));
		end
	end

	assign sts.main_due  = main_due;
	assign sts.last      = last_q;
	assign sts.tail_none = (back_q == '0);
	assign sts.tail_one  = (back_q == WIN_W'(1));
	assign sts.out_free  = !ovalid_q || out_ready;

	assign out_valid  = ovalid_q;
	assign value      = oval_q;
	assign averaged   = oavg_q;
	assign end_of_run = oend_q;

endmodule

>>> sv/centered_moving_average_filter.sv
// Top level of the centered moving average filter: controller plus datapath.
// Depends on cma_pkg, cma_in_if, cma_out_if, cma_ctrl and cma_datapath.
//
//   channel     direction  handshake     payload
//   samples     sink       valid/ready   sample, final_sample
//   results     source     valid/ready   value, averaged, end_of_run
//   cfg_*       sink       cfg_we        cfg_wdata (window_size)
//
// Each sample passes idle, update, multiply and, if it yields a word, emit;
// on the final sample each flushed tail word adds tail-read and tail-emit.
// The registered delay line read and reciprocal multiply set these steps.
// Reset: window 3, running sum, write pointer and sample count cleared;
// a window write also clears them. A word waits in the output register
// while the next sample is taken; a stalled sink holds the controller.
module centered_moving_average_filter #(
	parameter int MAX_WINDOW   = cma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = cma_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	cma_in_if.sink                         samples,
	cma_out_if.source                      results,
	input logic                            cfg_we,
	input logic [cma_pkg::WIN_FIELD_W-1:0] cfg_wdata
);
	import cma_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cma_datapath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.sample       (samples.sample),
		.final_sample (samples.final_sample),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.value        (results.value),
		.averaged     (results.averaged),
		.end_of_run   (results.end_of_run)
	);

endmodule
